@@ rtl/glpf_pkg.sv @@
package glpf_pkg;

  localparam int VALUE_BITS   = 32;
  localparam int TOTAL_W      = 48;
  localparam int POS_W        = 8;
  localparam int GRID_W       = 9;
  localparam int MAX_SIZE_DEF = 256;
  localparam int QUEUE_DEPTH  = 4;

  localparam logic [GRID_W-1:0] GRID_RESET = 9'd8;

  // result slots of one queue entry, emitted lowest index first
  localparam int MB_ABOVE = 0;
  localparam int MB_LEFT  = 1;
  localparam int MB_SELF  = 2;
  localparam int MB_TOTAL = 3;
  localparam int MASK_W   = 4;

  localparam logic KIND_PEAK  = 1'b0;
  localparam logic KIND_TOTAL = 1'b1;

  typedef logic signed [VALUE_BITS-1:0] value_t;
  typedef logic signed [TOTAL_W-1:0]    total_t;
  typedef logic [POS_W-1:0]             pos_t;

  // one row-buffer entry: the row above and the row two above
  typedef struct packed {
    value_t prev_val;
    value_t older_val;
  } row_pair_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    value_t            above_val;
    value_t            left_val;
    value_t            self_val;
    pos_t              row;
    pos_t              col;
  } q_entry_t;

  function automatic logic is_peak(
    input value_t v,
    input logic   hu, input value_t u,
    input logic   hd, input value_t d,
    input logic   hl, input value_t l,
    input logic   hr, input value_t r
  );
    logic res;
    res = !(hu && (u >= v)) && !(hd && (d >= v)) &&
          !(hl && (l >= v)) && !(hr && (r >= v));
    return res;
  endfunction

endpackage

@@ rtl/glpf_front.sv @@
module glpf_front #(
  parameter int MAX_SIZE = glpf_pkg::MAX_SIZE_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [glpf_pkg::GRID_W-1:0]   cfg_grid_size,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  glpf_pkg::value_t              in_cell_value,
  input  logic                          q_full,
  output logic                          q_push,
  output glpf_pkg::q_entry_t            q_push_entry
);

  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CMP_W = (IDX_W + 1 > glpf_pkg::GRID_W) ? IDX_W + 1 : glpf_pkg::GRID_W;

  function automatic logic [IDX_W-1:0] last_index(input logic [glpf_pkg::GRID_W-1:0] gs);
    logic [CMP_W-1:0] g;
    logic [CMP_W-1:0] lim;
    logic [IDX_W-1:0] res;
    g   = CMP_W'(gs);
    lim = CMP_W'(MAX_SIZE);
    if (g == '0) begin
      res = '0;
    end else if (g > lim) begin
      res = IDX_W'(lim - 1'b1);
    end else begin
      res = IDX_W'(g - 1'b1);
    end
    return res;
  endfunction

  glpf_pkg::row_pair_t mem [MAX_SIZE];

  logic [IDX_W-1:0]    row_r, row_nxt;
  logic [IDX_W-1:0]    col_r, col_nxt;
  logic [IDX_W-1:0]    col_b;
  logic [IDX_W-1:0]    last_r;
  glpf_pkg::row_pair_t rd_a_r;
  glpf_pkg::value_t    rd_b_r;
  glpf_pkg::value_t    prevp_r;
  glpf_pkg::value_t    rec0_r;
  glpf_pkg::value_t    rec1_r;
  glpf_pkg::row_pair_t wr_data;

  logic acc;
  logic wr_en;
  logic at_last_row;
  logic at_last_col;
  logic dec_above;
  logic dec_left;
  logic dec_self;
  logic [glpf_pkg::MASK_W-1:0] mask;

  // a grid_size write restarts the walk, so no cell is taken in that cycle
  assign in_stall    = q_full || cfg_we;
  assign acc         = in_valid && !in_stall;
  assign wr_en       = acc && !cfg_we;
  assign at_last_row = (row_r == last_r);
  assign at_last_col = (col_r == last_r);

  // above cell: its left neighbor is the row-above value read one transfer earlier
  assign dec_above = (row_r != '0) &&
    glpf_pkg::is_peak(rd_a_r.prev_val, row_r > IDX_W'(1), rd_a_r.older_val,
                      1'b1, in_cell_value, col_r != '0, prevp_r,
                      !at_last_col, rd_b_r);

  assign dec_left = at_last_row && (col_r != '0) &&
    glpf_pkg::is_peak(rec0_r, row_r != '0, prevp_r, 1'b0, '0,
                      col_r > IDX_W'(1), rec1_r, 1'b1, in_cell_value);

  assign dec_self = at_last_row && at_last_col &&
    glpf_pkg::is_peak(in_cell_value, row_r != '0, rd_a_r.prev_val, 1'b0, '0,
                      col_r != '0, rec0_r, 1'b0, '0);

  always_comb begin
    mask                     = '0;
    mask[glpf_pkg::MB_ABOVE] = dec_above;
    mask[glpf_pkg::MB_LEFT]  = dec_left;
    mask[glpf_pkg::MB_SELF]  = dec_self;
    mask[glpf_pkg::MB_TOTAL] = at_last_row && at_last_col;
  end

  assign q_push                 = wr_en && (mask != '0);
  assign q_push_entry.mask      = mask;
  assign q_push_entry.above_val = rd_a_r.prev_val;
  assign q_push_entry.left_val  = rec0_r;
  assign q_push_entry.self_val  = in_cell_value;
  assign q_push_entry.row       = glpf_pkg::POS_W'(row_r);
  assign q_push_entry.col       = glpf_pkg::POS_W'(col_r);

  assign wr_data.prev_val  = in_cell_value;
  assign wr_data.older_val = rd_a_r.prev_val;

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (cfg_we) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (acc) begin
      if (at_last_col) begin
        col_nxt = '0;
        row_nxt = at_last_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  assign col_b = col_nxt + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      last_r <= last_index(glpf_pkg::GRID_RESET);
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      if (cfg_we) begin
        last_r <= last_index(cfg_grid_size);
      end
    end
  end

  // row buffers; read data always tracks the next column, with write bypass
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[col_r] <= wr_data;
    end
    rd_a_r <= (wr_en && (col_r == col_nxt)) ? wr_data : mem[col_nxt];
    rd_b_r <= (wr_en && (col_r == col_b)) ? wr_data.prev_val : mem[col_b].prev_val;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      prevp_r <= rd_a_r.prev_val;
      rec1_r  <= rec0_r;
      rec0_r  <= in_cell_value;
    end
  end

endmodule

@@ rtl/glpf_queue.sv @@
module glpf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  glpf_pkg::q_entry_t push_entry,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output glpf_pkg::q_entry_t head_entry
);

  localparam int DEPTH = glpf_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  glpf_pkg::q_entry_t slots [DEPTH];

  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = slots[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ rtl/glpf_back.sv @@
module glpf_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic                       q_valid,
  input  glpf_pkg::q_entry_t         q_entry,
  output logic                       q_pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_item_kind,
  output glpf_pkg::value_t           out_peak_value,
  output glpf_pkg::pos_t             out_peak_row,
  output glpf_pkg::pos_t             out_peak_col,
  output glpf_pkg::total_t           out_running_total,
  output logic                       out_last
);

  glpf_pkg::q_entry_t          cur_r;
  logic [glpf_pkg::MASK_W-1:0] cur_mask_r;
  glpf_pkg::total_t            sum_r;

  logic                        out_valid_r;
  logic                        kind_r;
  glpf_pkg::value_t            value_r;
  glpf_pkg::pos_t              row_r;
  glpf_pkg::pos_t              col_r;
  glpf_pkg::total_t            total_r;

  logic                        load;
  logic                        one_left;
  logic [glpf_pkg::MASK_W-1:0] low_bit;
  logic                        kind_nxt;
  glpf_pkg::value_t            value_nxt;
  glpf_pkg::pos_t              row_nxt;
  glpf_pkg::pos_t              col_nxt;
  glpf_pkg::total_t            total_nxt;

  assign load     = (cur_mask_r != '0) && (!out_valid_r || !out_stall);
  assign low_bit  = cur_mask_r & (~cur_mask_r + 1'b1);
  assign one_left = ((cur_mask_r & (cur_mask_r - 1'b1)) == '0);
  assign q_pop    = q_valid && ((cur_mask_r == '0) || (load && one_left));

  always_comb begin
    kind_nxt  = glpf_pkg::KIND_PEAK;
    value_nxt = cur_r.self_val;
    row_nxt   = cur_r.row;
    col_nxt   = cur_r.col;
    priority if (cur_mask_r[glpf_pkg::MB_ABOVE]) begin
      value_nxt = cur_r.above_val;
      row_nxt   = cur_r.row - 1'b1;
    end else if (cur_mask_r[glpf_pkg::MB_LEFT]) begin
      value_nxt = cur_r.left_val;
      col_nxt   = cur_r.col - 1'b1;
    end else if (cur_mask_r[glpf_pkg::MB_SELF]) begin
      value_nxt = cur_r.self_val;
    end else begin
      kind_nxt  = glpf_pkg::KIND_TOTAL;
      value_nxt = '0;
      row_nxt   = '0;
      col_nxt   = '0;
    end
    total_nxt = (kind_nxt == glpf_pkg::KIND_TOTAL) ? sum_r
                                                   : sum_r + glpf_pkg::TOTAL_W'(value_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_mask_r  <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_mask_r <= q_entry.mask;
      end else if (load) begin
        cur_mask_r <= cur_mask_r & ~low_bit;
      end
      if (cfg_we) begin
        sum_r <= '0;
      end else if (load) begin
        sum_r <= (kind_nxt == glpf_pkg::KIND_TOTAL) ? '0 : total_nxt;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_entry;
    end
    if (load) begin
      kind_r  <= kind_nxt;
      value_r <= value_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      total_r <= total_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_item_kind     = kind_r;
  assign out_peak_value    = value_r;
  assign out_peak_row      = row_r;
  assign out_peak_col      = col_r;
  assign out_running_total = total_r;
  assign out_last          = (kind_r == glpf_pkg::KIND_TOTAL);

endmodule

@@ rtl/grid_local_peak_finder.sv @@
// A decided cell's report passes the queue, the entry register and output register.
// Throughput: one cell per cycle unless in_stall; the output stage gives one result
// per cycle unless out_stall, so a transfer deciding several cells holds the output
// for each in turn, and in_stall rises once four deciding transfers wait in the queue
// and in a grid_size write cycle. Reset: synchronous, active low; position, sum and
// queue clear, grid_size returns to 8. Row buffers are not cleared; no clearing pass.
module grid_local_peak_finder #(
  parameter int MAX_SIZE = glpf_pkg::MAX_SIZE_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [glpf_pkg::GRID_W-1:0] cfg_grid_size,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  glpf_pkg::value_t            in_cell_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_item_kind,
  output glpf_pkg::value_t            out_peak_value,
  output glpf_pkg::pos_t              out_peak_row,
  output glpf_pkg::pos_t              out_peak_col,
  output glpf_pkg::total_t            out_running_total,
  output logic                        out_last
);

  logic               cfg_we;
  logic               q_full;
  logic               q_push;
  glpf_pkg::q_entry_t q_push_entry;
  logic               q_pop;
  logic               q_valid;
  glpf_pkg::q_entry_t q_head;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  glpf_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_grid_size (cfg_grid_size),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cell_value (in_cell_value),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_push_entry  (q_push_entry)
  );

  glpf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_entry (q_head)
  );

  glpf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .q_valid           (q_valid),
    .q_entry           (q_head),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_peak_value    (out_peak_value),
    .out_peak_row      (out_peak_row),
    .out_peak_col      (out_peak_col),
    .out_running_total (out_running_total),
    .out_last          (out_last)
  );

endmodule

@@ rtl/glpf_checker.sv @@
module glpf_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic                  out_item_kind,
  input glpf_pkg::value_t      out_peak_value,
  input glpf_pkg::pos_t        out_peak_row,
  input glpf_pkg::pos_t        out_peak_col,
  input glpf_pkg::total_t      out_running_total,
  input logic                  out_last
);

  // set when the next result opens a grid's sum
  logic first_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      first_r <= 1'b1;
    end else if (out_valid && !out_stall) begin
      first_r <= out_last;
    end
  end

  a_total_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_item_kind == glpf_pkg::KIND_TOTAL)) &&
                  (!out_last || ((out_peak_value == '0) && (out_peak_row == '0) &&
                                 (out_peak_col == '0))))
    else $error("total item malformed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_running_total) &&
                               $stable(out_peak_value) && $stable(out_last))
    else $error("stalled result changed");

  a_sum_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && first_r |->
      (out_running_total == (out_last ? '0 : glpf_pkg::TOTAL_W'(out_peak_value))))
    else $error("running total did not restart");

endmodule

bind grid_local_peak_finder glpf_checker u_glpf_checker (.*);

@@ verif/tb_grid_local_peak_finder.sv @@
`timescale 1ns / 1ps

module tb_grid_local_peak_finder;

  localparam int MAX_SIDE    = glpf_pkg::MAX_SIZE_DEF;
  localparam int DRAIN_WAIT  = 12;     // a bit above the report latency
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_CELLS = 60;

  typedef enum int {STYLE_TIES, STYLE_WIDE, STYLE_MIXED} value_style_t;
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;

  typedef struct {
    logic             kind;
    glpf_pkg::value_t value;
    glpf_pkg::pos_t   row;
    glpf_pkg::pos_t   col;
    glpf_pkg::total_t total;
    logic             last;
  } peak_report_t;

  // Tracks the grid walk and holds the reports the block owes us.
  class peak_tracker;
    glpf_pkg::value_t above_row[MAX_SIDE];   // row just above the arriving cell
    glpf_pkg::value_t upper_row[MAX_SIDE];   // two rows up, left part already shifted
    glpf_pkg::value_t last_cell;
    glpf_pkg::value_t cell_before;
    int unsigned      side;
    int unsigned      row;
    int unsigned      col;
    glpf_pkg::total_t peak_total;
    peak_report_t     owed[$];
    int unsigned      errors;

    function new();
      side = 32'(glpf_pkg::GRID_RESET);
      row = 0;
      col = 0;
      peak_total = '0;
      errors = 0;
      last_cell = '0;
      cell_before = '0;
      foreach (above_row[i]) begin
        above_row[i] = '0;
        upper_row[i] = '0;
      end
    endfunction

    function void set_size(logic [glpf_pkg::GRID_W-1:0] v);
      if (v == '0) side = 1;
      else if (v > MAX_SIDE) side = MAX_SIDE;
      else side = 32'(v);
      row = 0;
      col = 0;
      peak_total = '0;
    endfunction

    function bit beats(glpf_pkg::value_t v, bit hu, glpf_pkg::value_t u,
                       bit hd, glpf_pkg::value_t d, bit hl, glpf_pkg::value_t l,
                       bit hr, glpf_pkg::value_t rt);
      return !(hu && u >= v) && !(hd && d >= v) && !(hl && l >= v) && !(hr && rt >= v);
    endfunction

    function void log_peak(glpf_pkg::value_t v, int unsigned r, int unsigned c);
      peak_report_t rep;
      peak_total = peak_total + glpf_pkg::total_t'(v);
      rep = '{kind: glpf_pkg::KIND_PEAK, value: v, row: glpf_pkg::pos_t'(r),
              col: glpf_pkg::pos_t'(c), total: peak_total, last: 1'b0};
      owed.push_back(rep);
    endfunction

    function void note_cell(glpf_pkg::value_t v);
      int unsigned      n;
      int unsigned      r;
      int unsigned      c;
      glpf_pkg::value_t val;
      glpf_pkg::value_t lv;
      glpf_pkg::value_t rv;
      peak_report_t     rep;
      n = side;
      r = row;
      c = col;
      // the cell above is now fully surrounded
      if (r > 0) begin
        val = above_row[c];
        lv  = (c > 0) ? upper_row[c-1] : '0;
        rv  = (c + 1 < n) ? above_row[c+1] : '0;
        if (beats(val, r > 1, upper_row[c], 1'b1, v, c > 0, lv, c + 1 < n, rv))
          log_peak(val, r - 1, c);
      end
      upper_row[c] = above_row[c];
      above_row[c] = v;
      // bottom row: decided along the row
      if (r == n - 1) begin
        if (c > 0) begin
          if (beats(last_cell, r > 0, upper_row[c-1], 1'b0, '0,
                    c > 1, cell_before, 1'b1, v))
            log_peak(last_cell, r, c - 1);
        end
        if (c == n - 1) begin
          if (beats(v, r > 0, upper_row[c], 1'b0, '0, c > 0, last_cell, 1'b0, '0))
            log_peak(v, r, c);
          rep = '{kind: glpf_pkg::KIND_TOTAL, value: '0, row: '0, col: '0,
                  total: peak_total, last: 1'b1};
          owed.push_back(rep);
        end
      end
      cell_before = last_cell;
      last_cell = v;
      if (r == n - 1 && c == n - 1) begin
        row = 0;
        col = 0;
        peak_total = '0;
      end else if (c + 1 >= n) begin
        col = 0;
        row = r + 1;
      end else begin
        col = c + 1;
      end
    endfunction

    function void check_report(peak_report_t got);
      peak_report_t exp;
      if (owed.size() == 0) begin
        $error("unexpected result: kind %0d value %0d row %0d col %0d total %0d",
               got.kind, got.value, got.row, got.col, got.total);
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.kind !== exp.kind) begin
        $error("item_kind: expected %0d, got %0d", exp.kind, got.kind);
        errors++;
      end
      if (got.value !== exp.value) begin
        $error("peak_value: expected %0d, got %0d", exp.value, got.value);
        errors++;
      end
      if (got.row !== exp.row) begin
        $error("peak_row: expected %0d, got %0d", exp.row, got.row);
        errors++;
      end
      if (got.col !== exp.col) begin
        $error("peak_col: expected %0d, got %0d", exp.col, got.col);
        errors++;
      end
      if (got.total !== exp.total) begin
        $error("running_total: expected %0d, got %0d", exp.total, got.total);
        errors++;
      end
      if (got.last !== exp.last) begin
        $error("last: expected %0d, got %0d", exp.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [glpf_pkg::GRID_W-1:0] cfg_grid_size = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  glpf_pkg::value_t            in_cell_value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic                        out_item_kind;
  glpf_pkg::value_t            out_peak_value;
  glpf_pkg::pos_t              out_peak_row;
  glpf_pkg::pos_t              out_peak_col;
  glpf_pkg::total_t            out_running_total;
  logic                        out_last;

  peak_tracker tracker = new();
  int unsigned cycle_count = 0;
  int unsigned burst_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned stall_span = 0;

  grid_local_peak_finder u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_grid_size     (cfg_grid_size),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cell_value     (in_cell_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_item_kind     (out_item_kind),
    .out_peak_value    (out_peak_value),
    .out_peak_row      (out_peak_row),
    .out_peak_col      (out_peak_col),
    .out_running_total (out_running_total),
    .out_last          (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_grid_local_peak_finder: done, errors");
      $finish;
    end
  end

  // receiver: stall pattern switches between modes after a random span
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(20, 80);
    end
    stall_span--;
    case (stall_mode)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
      default:     out_stall = ~out_stall;
    endcase
  end

  always @(posedge clk) begin
    peak_report_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = '{kind: out_item_kind, value: out_peak_value, row: out_peak_row,
              col: out_peak_col, total: out_running_total, last: out_last};
      tracker.check_report(got);
    end
  end

  function automatic glpf_pkg::value_t pick_value(value_style_t style);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (style == STYLE_TIES || (style == STYLE_MIXED && sel < 5))
      return $urandom_range(0, 6) - 3;
    if (style == STYLE_WIDE || sel < 8)
      return $urandom;
    case ($urandom_range(0, 3))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  // called and returns at a falling edge; valid stays up between back-to-back cells
  task automatic push_cell(glpf_pkg::value_t v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid = 1'b1;
    in_cell_value = v;
    do @(posedge clk); while (in_stall);
    tracker.note_cell(v);
    burst_left--;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (tracker.owed.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_size(logic [glpf_pkg::GRID_W-1:0] v);
    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_grid_size = v;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_size(v);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic send_cells(int unsigned count, value_style_t style, bit may_pause);
    for (int unsigned i = 0; i < count; i++) begin
      if (may_pause && $urandom_range(0, 99) < 2)
        wait_drained();
      push_cell(pick_value(style));
    end
  endtask

  task automatic send_list(glpf_pkg::value_t cells[$]);
    foreach (cells[i]) push_cell(cells[i]);
  endtask

  initial begin
    glpf_pkg::value_t            cells[$];
    int unsigned                 sent;
    int unsigned                 side;
    int unsigned                 count;
    logic [glpf_pkg::GRID_W-1:0] size_code;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    // reset grid size
    send_cells(64, STYLE_MIXED, 1'b0);

    // value extremes on single cells, size zero taken as one
    write_size(9'd1);
    cells = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sd1};
    send_list(cells);
    write_size(9'd0);
    cells = '{32'sd5, -32'sd5};
    send_list(cells);
    // plateau gives no peak; then a lone maximum in a corner and in the centre
    write_size(9'd2);
    cells = '{32'sd7, 32'sd7, 32'sd7, 32'sd7, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh8000_0000, 32'sh8000_0000};
    send_list(cells);
    write_size(9'd3);
    cells = '{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd9, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
    send_list(cells);

    // oversize code saturates; grid abandoned early in its second row
    write_size('1);
    send_cells(MAX_SIDE + 8, STYLE_WIDE, 1'b1);

    sent = 0;
    while (sent < RANDOM_CELLS) begin
      case ($urandom_range(0, 9))
        0:       size_code = '0;
        1, 2:    size_code = glpf_pkg::GRID_W'($urandom_range(6, 9));
        default: size_code = glpf_pkg::GRID_W'($urandom_range(1, 5));
      endcase
      write_size(size_code);
      side = (size_code == '0) ? 1 : 32'(size_code);
      count = $urandom_range(1, 2) * side * side;
      // now and then cut the last grid short; the next size write drops it
      if ($urandom_range(0, 5) == 0)
        count = count - $urandom_range(0, side * side - 1);
      send_cells(count, value_style_t'($urandom_range(0, 2)), 1'b1);
      sent += count;
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.errors == 0)
      $display("tb_grid_local_peak_finder: done, clean");
    else
      $display("tb_grid_local_peak_finder: done, errors");
    $finish;
  end

endmodule
